>>> src/fpalu_pkg.sv
package fpalu_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_W = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_OVF = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	// classified request between front and back
	typedef struct packed {
		logic        is_div;
		logic        is_mul;
		logic        divz;
		logic        neg;
		logic [31:0] mag_a;
		logic [31:0] mag_b;
		logic [31:0] value;
		logic        cmp;
		logic [1:0]  status;
	} req_t;

	typedef struct packed {
		logic [31:0] value;
		logic        cmp;
		logic [1:0]  status;
	} res_t;

	function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag,
			output logic ovf);
		logic [31:0] r;
		begin
			ovf = 1'b0;
			if (neg) begin
				if (mag > 64'h8000_0000) begin
					ovf = 1'b1;
					r = 32'h8000_0000;
				end else begin
					r = 32'd0 - mag[31:0];
				end
			end else begin
				if (mag > 64'h7FFF_FFFF) begin
					ovf = 1'b1;
					r = 32'h7FFF_FFFF;
				end else begin
					r = mag[31:0];
				end
			end
			return r;
		end
	endfunction

endpackage

>>> src/fixed_point_alu.sv
// channel | dir | tdata (low to high)                          | tuser
// s_axis  | in  | operation[3:0] a[35:4] b[67:36], pad to 72   | -
// m_axis  | out | result_value[31:0] compare_true[32] status[34:33], pad to 40 | -
// One request per cycle sustained while the output is not stalled; a result passes
// through the queue, the one-bit-per-stage divider pipeline and the output register.
// Reset clears queue and stage valids.
// A stalled output holds the whole back pipeline; the queue absorbs requests.
module fixed_point_alu
	import fpalu_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // operation, operand_a, operand_b
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // result_value, compare_true, status
);
	req_t fr, qd;
	logic qv, qr;
	res_t rs;

	fpalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.operation(s_axis_tdata[3:0]),
		.operand_a(s_axis_tdata[35:4]),
		.operand_b(s_axis_tdata[67:36]),
		.req(fr)
	);

	fpalu_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(fr),
		.out_valid(qv), .out_ready(qr), .out_data(qd)
	);

	fpalu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(qv), .in_ready(qr), .in_data(qd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(rs)
	);

	assign m_axis_tdata = {5'd0, rs.status, rs.cmp, rs.value};
endmodule

>>> src/fpalu_front.sv
module fpalu_front
	import fpalu_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic [3:0]  operation,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output req_t        req
);
	logic signed [31:0] a, b;
	logic signed [32:0] sum, dif, inc, dec;
	logic signed [63:0] sh;
	logic lt, eq, ovf;
	logic [31:0] r;
	logic [1:0] st;
	logic c;

	assign a = operand_a;
	assign b = operand_b;
	assign lt = a < b;
	assign eq = a == b;
	assign sum = {a[31], a} + {b[31], b};
	assign dif = {a[31], a} - {b[31], b};
	assign inc = {a[31], a} + 33'sd1;
	assign dec = {a[31], a} - 33'sd1;
	assign sh = 64'(signed'(a)) <<< FRAC_BITS;

	function automatic logic [31:0] clamp33(input logic signed [32:0] v, output logic o);
		begin
			o = v[32] != v[31];
			return o ? (v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : v[31:0];
		end
	endfunction

	always_comb begin
		r = '0;
		c = 1'b0;
		st = ST_OK;
		ovf = 1'b0;
		unique case (op_t'(operation))
			OP_ADD: r = clamp33(sum, ovf);
			OP_SUB: r = clamp33(dif, ovf);
			OP_INC: r = clamp33(inc, ovf);
			OP_DEC: r = clamp33(dec, ovf);
			OP_MUL, OP_DIV: r = '0;
			OP_GT: c = !lt && !eq;
			OP_LT: c = lt;
			OP_GE: c = !lt;
			OP_LE: c = lt || eq;
			OP_EQ: c = eq;
			OP_NE: c = !eq;
			OP_MIN: r = (lt || eq) ? a : b;
			OP_MAX: r = !lt ? a : b;
			OP_TOINT: r = 32'(a >>> FRAC_BITS);
			OP_FROMINT: begin
				if (sh > 64'sh7FFF_FFFF) begin
					ovf = 1'b1;
					r = 32'h7FFF_FFFF;
				end else if (sh < -64'sh8000_0000) begin
					ovf = 1'b1;
					r = 32'h8000_0000;
				end else begin
					r = sh[31:0];
				end
			end
			default: r = '0;
		endcase
		if (ovf)
			st = ST_OVF;
		req.is_div = operation == OP_DIV;
		req.is_mul = operation == OP_MUL;
		req.divz = b == 0;
		req.neg = a[31] ^ b[31];
		req.mag_a = a[31] ? 32'd0 - a : a;
		req.mag_b = b[31] ? 32'd0 - b : b;
		req.value = r;
		req.cmp = c;
		req.status = st;
	end
endmodule

>>> src/fpalu_queue.sv
module fpalu_queue
	import fpalu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output req_t out_data
);
	req_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wp_q, rp_q;
	logic [QUEUE_AW:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
		end
	end
endmodule

>>> src/fpalu_back.sv
module fpalu_back
	import fpalu_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);
	localparam int NW = 33 + FRAC_BITS;
	localparam int NS = NW;

	logic [NS:0] vld_q;
	logic adv;
	req_t   rq_s [NS+1];
	logic [NW-1:0] rem_s [NS+1];
	logic [NW-1:0] num_s [NS+1];
	logic [NW:0]   quo_s [NS+1];
	logic [63:0]   prod_s [NS+1];
	res_t out_q;
	logic out_v_q;
	logic [NW:0] q_fin;
	logic [63:0] m_fin;
	logic [63:0] mag_fin;
	logic ovf_fin;
	logic [31:0] r_fin;
	res_t res_fin;

	assign adv = !out_v_q || out_ready;
	assign in_ready = adv;
	assign out_valid = out_v_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[NS-1:0], in_valid};
			out_v_q <= vld_q[NS];
		end
	end

	// stage 0: load 2*mag_a<<F numerator, multiply
	always_ff @(posedge clk) begin
		if (adv) begin
			rq_s[0] <= in_data;
			num_s[0] <= NW'({in_data.mag_a, 1'b0}) << FRAC_BITS;
			rem_s[0] <= '0;
			quo_s[0] <= '0;
			prod_s[0] <= 64'(in_data.mag_a) * 64'(in_data.mag_b);
		end
	end

	// long division of (2n) by d, one bit a stage; q = floor((2n+d)/(2d)) = round(n/d)
	for (genvar i = 0; i < NS; i++) begin : g_div
		logic [NW:0] tr;
		logic ge;
		assign tr = {rem_s[i], num_s[i][NW-1]};
		assign ge = tr >= (NW+1)'(rq_s[i].mag_b);
		always_ff @(posedge clk) begin
			if (adv) begin
				rq_s[i+1] <= rq_s[i];
				prod_s[i+1] <= prod_s[i];
				num_s[i+1] <= num_s[i] << 1;
				rem_s[i+1] <= ge ? NW'(tr - (NW+1)'(rq_s[i].mag_b)) : NW'(tr);
				quo_s[i+1] <= {quo_s[i][NW-1:0], ge};
			end
		end
	end

	always_comb begin
		// quotient of 2n/d; rounding: (2n/d + 1) / 2
		q_fin = (quo_s[NS] + (NW+1)'(1)) >> 1;
		m_fin = prod_s[NS] + (64'd1 << (FRAC_BITS - 1));
		if (rq_s[NS].is_mul)
			mag_fin = m_fin >> FRAC_BITS;
		else
			mag_fin = 64'(q_fin);
		r_fin = sat_mag(rq_s[NS].neg && mag_fin != 0, mag_fin, ovf_fin);
		res_fin.value = rq_s[NS].value;
		res_fin.cmp = rq_s[NS].cmp;
		res_fin.status = rq_s[NS].status;
		if (rq_s[NS].is_div && rq_s[NS].divz) begin
			res_fin.value = '0;
			res_fin.status = ST_DIVZ;
		end else if (rq_s[NS].is_div || rq_s[NS].is_mul) begin
			res_fin.value = r_fin;
			res_fin.status = ovf_fin ? ST_OVF : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_q[NS])
			out_q <= res_fin;
	end
endmodule

>>> src/fpalu_checker.sv
module fpalu_checker
	import fpalu_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[34:33] != 2'd3)
		else $error("bad status");
	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0
		&& m_axis_tdata[34:33] == ST_OK)
		else $error("compare with value");
	a_divz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[34:33] == ST_DIVZ |-> m_axis_tdata[31:0] == 32'd0)
		else $error("div zero value");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
		else $error("pad bits");
endmodule

bind fixed_point_alu fpalu_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

>>> verif/tb_fixed_point_alu.sv
module tb_fixed_point_alu;
	import fpalu_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = 36 + FB;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		op_t         opc;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct {
		logic [31:0] value;
		logic        cmp;
		logic [1:0]  status;
	} alu_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;

	alu_req_t pending_reqs[$];
	alu_res_t expected_results[$];
	int       mismatches;
	int       cycle_count;
	int       send_gap;
	int       recv_gap;
	int       hold_off;
	bit       stim_done;

	fixed_point_alu #(.FRAC_BITS(FB)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic alu_res_t predict_alu(alu_req_t rq);
		alu_res_t res;
		logic signed [63:0] sa;
		logic signed [63:0] sb;
		logic signed [63:0] v;
		logic [63:0] mag;
		logic [63:0] n;
		logic [63:0] d;
		logic neg;
		res = '{32'd0, 1'b0, ST_OK};
		sa = {{32{rq.a[31]}}, rq.a};
		sb = {{32{rq.b[31]}}, rq.b};
		v = 0;
		neg = 1'b0;
		mag = 0;
		case (rq.opc)
			OP_ADD: v = sa + sb;
			OP_SUB: v = sa - sb;
			OP_INC: v = sa + 1;
			OP_DEC: v = sa - 1;
			OP_FROMINT: v = sa <<< FB;
			OP_MUL: begin
				v = sa * sb;
				neg = v < 0;
				mag = neg ? -v : v;
				mag = (mag + (64'd1 << (FB - 1))) >> FB;
			end
			OP_DIV: begin
				if (sb != 0) begin
					neg = (sa < 0) != (sb < 0);
					n = (sa < 0 ? -sa : sa) << FB;
					d = sb < 0 ? -sb : sb;
					mag = (2 * n + d) / (2 * d);
				end
			end
			default: ;
		endcase
		case (rq.opc)
			OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_FROMINT: begin
				if (v > 64'sd2147483647) begin
					res.value = 32'h7FFF_FFFF;
					res.status = ST_OVF;
				end else if (v < -64'sd2147483648) begin
					res.value = 32'h8000_0000;
					res.status = ST_OVF;
				end else begin
					res.value = v[31:0];
				end
			end
			OP_MUL, OP_DIV: begin
				if (rq.opc == OP_DIV && sb == 0) begin
					res.status = ST_DIVZ;
				end else if (neg ? mag > 64'h8000_0000 : mag > 64'h7FFF_FFFF) begin
					res.value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
					res.status = ST_OVF;
				end else begin
					res.value = neg ? 32'd0 - mag[31:0] : mag[31:0];
				end
			end
			OP_GT: res.cmp = sa > sb;
			OP_LT: res.cmp = sa < sb;
			OP_GE: res.cmp = sa >= sb;
			OP_LE: res.cmp = sa <= sb;
			OP_EQ: res.cmp = sa == sb;
			OP_NE: res.cmp = sa != sb;
			OP_MIN: res.value = (sa <= sb) ? rq.a : rq.b;
			OP_MAX: res.value = (sa >= sb) ? rq.a : rq.b;
			OP_TOINT: res.value = $signed(rq.a) >>> FB;
			default: ;
		endcase
		return res;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 3) - 1;
			3, 4: return $urandom_range(0, 1 << 16) - (1 << 15);
			5: return $urandom_range(0, 1 << 24) - (1 << 23);
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	task automatic queue_req(op_t opc, logic [31:0] a, logic [31:0] b);
		alu_req_t rq;
		rq.opc = opc;
		rq.a = a;
		rq.b = b;
		pending_reqs.push_back(rq);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		op_t opc;
		stim_done = 1'b0;
		for (int i = 0; i < 16; i++) begin
			opc = op_t'(i);
			queue_req(opc, 32'h7FFF_FFFF, 32'h8000_0000);
		end
		queue_req(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_req(OP_MUL, 32'h8000_0000, 32'h8000_0000);
		queue_req(OP_MUL, 32'hFFFF_FF80, 32'h0000_0001);
		queue_req(OP_DIV, 32'h0000_0100, 32'h0000_0000);
		queue_req(OP_DIV, 32'h8000_0000, 32'hFFFF_FF00);
		queue_req(OP_MIN, 32'h1234_5678, 32'h1234_5678);
		queue_req(OP_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_req(OP_TOINT, 32'hFFFF_FFFF, 32'h0);
		queue_req(OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < 400; i++) begin
			opc = op_t'($urandom_range(0, 15));
			queue_req(opc, rand_operand(), ($urandom_range(0, 15) == 0) ? 32'd0 : rand_operand());
		end
		stim_done = 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(predict_alu(pending_reqs.pop_front()));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					s_axis_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_reqs.size() > 0) begin
					alu_req_t nx;
					nx = pending_reqs[0];
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'd0, nx.b, nx.a, nx.opc};
					send_gap <= rand_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
			hold_off <= 0;
		end else begin
			if (cycle_count == 300) begin
				hold_off <= 200;
				m_axis_tready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_gap <= (cycle_count > 5000 && cycle_count < 8000) ? 0 : rand_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_axis_tdata);
				mismatches++;
			end else begin
				alu_res_t ex;
				ex = expected_results.pop_front();
				if (m_axis_tdata[31:0] !== ex.value || m_axis_tdata[32] !== ex.cmp
						|| m_axis_tdata[34:33] !== ex.status) begin
					$display("%0t: expected value %h cmp %b status %0d, actual value %h cmp %b status %0d",
						$time, ex.value, ex.cmp, ex.status,
						m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[34:33]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		cycle_count = 0;
		@(posedge arst_n);
		while (!(stim_done && pending_reqs.size() == 0 && !s_axis_tvalid
				&& expected_results.size() == 0) && cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
		end else begin
			repeat (LATENCY * 2) @(posedge clk);
			if (mismatches == 0 && expected_results.size() == 0)
				$display("end of test: clean");
			else
				$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> sim.f
src/fpalu_pkg.sv
src/fpalu_front.sv
src/fpalu_queue.sv
src/fpalu_back.sv
src/fixed_point_alu.sv
src/fpalu_checker.sv
verif/tb_fixed_point_alu.sv
